[rtl/core/gbir_pkg.sv]
// Package for the grouped block index remap: field widths, derived widths and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
package gbir_pkg;

    localparam int ROW_W      = 48;
    localparam int OUT_W      = 51;
    localparam int BS_W       = 32;
    localparam int GC_W       = 3;
    localparam int GS_W       = 32;
    localparam int TOT_W      = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_LO_W   = 32;
    localparam int MUL_HI_W   = OUT_W - MUL_LO_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BLOCK_SIZE  = 3'd0;
    localparam t_cfg_idx CFG_GROUP_COUNT = 3'd1;
    localparam t_cfg_idx CFG_GROUP_SIZE0 = 3'd2;

endpackage

[rtl/core/gbir_in_if.sv]
// Input channel of the grouped block index remap: valid, ready and row id.
// Depends on gbir_pkg.
`timescale 1ns / 1ps
interface gbir_in_if import gbir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_id;

    modport source (output valid, output row_id, input ready);
    modport sink   (input valid, input row_id, output ready);
endinterface

[rtl/core/gbir_out_if.sv]
// Result channel of the grouped block index remap: valid, ready, index and
// fault flag. Depends on gbir_pkg.
`timescale 1ns / 1ps
interface gbir_out_if import gbir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] mapped_index;
    logic             fault;

    modport source (output valid, output mapped_index, output fault, input ready);
    modport sink   (input valid, input mapped_index, input fault, output ready);
endinterface

[rtl/core/gbir_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband that travels alongside. Depends on gbir_pkg only by convention.
`timescale 1ns / 1ps
module gbir_div import gbir_pkg::*; #(
    parameter int DW = 48,
    parameter int VW = 32,
    parameter int SW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_valid [DW];
    logic [VW-1:0] r_rem   [DW];
    logic [DW-1:0] r_dq    [DW];
    logic [SW-1:0] r_side  [DW];

    for (genvar s = 0; s < DW; s++) begin : g_stage
        logic          vld_in;
        logic [VW-1:0] rem_in;
        logic [DW-1:0] dq_in;
        logic [SW-1:0] side_in;
        logic [VW:0]   trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign dq_in   = i_dividend;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_valid[s-1];
            assign rem_in  = r_rem[s-1];
            assign dq_in   = r_dq[s-1];
            assign side_in = r_side[s-1];
        end

        assign trial = {rem_in, dq_in[DW-1]};
        assign ge    = trial >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= vld_in;
            end
            if (i_en) begin
                r_rem[s]  <= ge ? VW'(trial - {1'b0, i_divisor}) : trial[VW-1:0];
                r_dq[s]   <= {dq_in[DW-2:0], ge};
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[DW-1];
    assign o_quot  = r_dq[DW-1];
    assign o_rem   = r_rem[DW-1];
    assign o_side  = r_side[DW-1];

endmodule

[rtl/core/grouped_block_index_remap.sv]
// Grouped block index remap: top level with configuration registers, two
// pipelined dividers, group search, split multiply and output register.
// Depends on gbir_pkg, gbir_in_if, gbir_out_if and gbir_div.
//
// Usage: row ids arrive on i_row (valid/ready); one result per row id leaves
// on o_res (valid/ready) in the order of arrival. Each transfer on i_row
// gives exactly one transfer on o_res carrying the mapped index and a fault
// flag, which is set with a zero index when the block size or group total
// is zero. Configuration is written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write it only while no row id is in flight,
// as the block does not enforce this. Each row id passes the 48 stages of
// the block division, the 48 of the division by the group total, group
// search, the partial products and the output register. Throughput is one
// row id per cycle unless stalled; every stage moves on a single enable
// that is high whenever the output register is empty or being emptied.
// When the receiver holds o_res.ready low with a result waiting, the whole
// pipeline holds and i_row.ready falls; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets each config register to 1.
`timescale 1ns / 1ps
module grouped_block_index_remap import gbir_pkg::*; #(
    parameter int MAX_GROUPS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gbir_in_if.sink               i_row,
    gbir_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [BS_W-1:0]  r_block_size;
    logic [GC_W-1:0]  r_group_count;
    logic [GS_W-1:0]  r_group_size [MAX_GROUPS];

    logic [TOT_W-1:0] r_total, n_total;
    logic [TOT_W-1:0] r_prefix [MAX_GROUPS];
    logic [TOT_W-1:0] n_prefix [MAX_GROUPS];
    logic [GC_W-1:0]  r_gsat, n_gsat;
    logic             r_fault, n_fault;

    logic             en;

    logic             d1_valid;
    logic [ROW_W-1:0] d1_quot;
    logic [BS_W-1:0]  d1_rem;
    logic [0:0]       d1_side;

    logic             d2_valid;
    logic [ROW_W-1:0] d2_quot;
    logic [TOT_W-1:0] d2_rem;
    logic [BS_W-1:0]  d2_side;

    logic [GC_W-1:0]  grp;

    logic              r_a_valid;
    logic [OUT_W-1:0]  r_a_idx;
    logic [BS_W-1:0]   r_a_rem;

    logic                  r_b_valid;
    logic [2*MUL_LO_W-1:0] r_b_lo;
    logic [MUL_HI_W-1:0]   r_b_hi;
    logic [BS_W-1:0]       r_b_rem;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_index;
    logic             r_out_fault;
    logic [OUT_W-1:0] n_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BS_W'(1);
            r_group_count <= GC_W'(1);
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_group_size[i] <= GS_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_SIZE: begin
                    r_block_size <= i_cfg_data[BS_W-1:0];
                end
                CFG_GROUP_COUNT: begin
                    r_group_count <= i_cfg_data[GC_W-1:0];
                end
                default: begin
                    for (int i = 0; i < MAX_GROUPS; i++) begin
                        if (i_cfg_idx == CFG_IDX_W'(CFG_GROUP_SIZE0 + i)) begin
                            r_group_size[i] <= i_cfg_data[GS_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        logic [TOT_W-1:0] acc;
        acc     = '0;
        n_total = '0;
        n_gsat  = (r_group_count > GC_W'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS) : r_group_count;
        for (int i = 0; i < MAX_GROUPS; i++) begin
            acc         = acc + TOT_W'(r_group_size[i]);
            n_prefix[i] = acc;
            if (GC_W'(i) < n_gsat) begin
                n_total = n_total + TOT_W'(r_group_size[i]);
            end
        end
        n_fault = (r_block_size == '0) || (n_total == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOT_W'(1);
            r_gsat  <= GC_W'(1);
            r_fault <= 1'b0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_prefix[i] <= TOT_W'(i + 1);
            end
        end else begin
            r_total  <= n_total;
            r_gsat   <= n_gsat;
            r_fault  <= n_fault;
            r_prefix <= n_prefix;
        end
    end

    assign en          = !r_out_valid || o_res.ready;
    assign i_row.ready = en;

    gbir_div #(
        .DW (ROW_W),
        .VW (BS_W),
        .SW (1)
    ) u_div_block (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_row.valid),
        .i_dividend (ROW_W'(i_row.row_id - ROW_W'(1))),
        .i_divisor  (r_block_size),
        .i_side     (1'b0),
        .o_valid    (d1_valid),
        .o_quot     (d1_quot),
        .o_rem      (d1_rem),
        .o_side     (d1_side)
    );

    gbir_div #(
        .DW (ROW_W),
        .VW (TOT_W),
        .SW (BS_W)
    ) u_div_total (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d1_valid && !d1_side[0]),
        .i_dividend (d1_quot),
        .i_divisor  (r_total),
        .i_side     (d1_rem),
        .o_valid    (d2_valid),
        .o_quot     (d2_quot),
        .o_rem      (d2_rem),
        .o_side     (d2_side)
    );

    always_comb begin
        grp = r_gsat - GC_W'(1);
        for (int i = MAX_GROUPS - 2; i >= 0; i--) begin
            if ((GC_W'(i + 1) < r_gsat) && (d2_rem < r_prefix[i])) begin
                grp = GC_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= d2_valid;
            r_b_valid <= r_a_valid;
        end
        if (en) begin
            r_a_idx <= OUT_W'(grp) + OUT_W'(d2_quot) * OUT_W'(r_gsat);
            r_a_rem <= d2_side;
            r_b_lo  <= r_a_idx[MUL_LO_W-1:0] * r_block_size;
            r_b_hi  <= MUL_HI_W'(r_a_idx[OUT_W-1:MUL_LO_W] * r_block_size[MUL_HI_W-1:0]);
            r_b_rem <= r_a_rem;
        end
    end

    assign n_index = r_b_lo[OUT_W-1:0] + {r_b_hi, {MUL_LO_W{1'b0}}}
                   + OUT_W'(r_b_rem) + OUT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_b_valid;
        end
        if (en) begin
            r_out_index <= r_fault ? '0 : n_index;
            r_out_fault <= r_fault;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.mapped_index = r_out_index;
    assign o_res.fault        = r_out_fault;

`ifndef SYNTH
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.fault |-> o_res.mapped_index == '0)
        else $error("faulted result carries a non-zero index");

    a_groups_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fault |-> r_gsat != '0)
        else $error("no fault flagged although no group is in use");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid straight after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_row.ready)
        else $error("input stalled with an empty output register");
`endif

endmodule
